### hdl/plcr_pkg.sv
// Package: shared types and constants for the per-line CDP range table.
`default_nettype none

package plcr_pkg;

    localparam int CdpW   = 16;
    localparam int LineW  = 16;
    localparam int SpanW  = 17;
    localparam int CountW = 32;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_RD_LINE = 2'd1,
        CMD_RD_PROJ = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_OUTSIDE = 2'd1,
        STS_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_CLR,
        ST_IDLE,
        ST_BUSY
    } t_state;

    // One table entry: least CDP, greatest CDP, trace count.
    typedef struct packed {
        logic [CdpW-1:0]   low;
        logic [CdpW-1:0]   high;
        logic [CountW-1:0] count;
    } t_entry;

    typedef struct packed {
        logic            seen;
        logic [CdpW-1:0] low;
        logic [CdpW-1:0] high;
    } t_proj;

    typedef struct packed {
        t_status           status;
        logic [CdpW-1:0]   cdp_min;
        logic [CdpW-1:0]   cdp_max;
        logic [SpanW-1:0]  cdp_span;
        logic [CountW-1:0] trace_count;
        logic [CdpW-1:0]   proj_cdp_min;
        logic [CdpW-1:0]   proj_cdp_max;
    } t_result;

endpackage

`default_nettype wire

### hdl/plcr_ram.sv
// Module: single-port-write, registered-read table memory for line entries.
`default_nettype none

module plcr_ram
    import plcr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  t_entry             i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/plcr_calc.sv
// Module: entry update and result formation for one item.
`default_nettype none

module plcr_calc
    import plcr_pkg::*;
(
    input  t_cmd                  i_cmd,
    input  wire logic             i_in_range,
    input  wire logic [CdpW-1:0]  i_cdp,
    input  t_entry                i_entry,
    input  t_proj                 i_proj,
    output logic                  o_wr_en,
    output t_entry                o_wr_entry,
    output t_proj                 o_proj_next,
    output t_result               o_result
);

    t_entry  w_upd;
    t_entry  w_line;
    t_proj   w_proj_upd;
    t_proj   w_proj;
    t_result w_res;
    logic    w_empty;

    always_comb begin
        w_empty = (i_entry.count == '0);

        // add: widen the line's range and bump the saturating count
        w_upd.low   = (w_empty || (i_cdp < i_entry.low))  ? i_cdp : i_entry.low;
        w_upd.high  = (w_empty || (i_cdp > i_entry.high)) ? i_cdp : i_entry.high;
        w_upd.count = (&i_entry.count) ? i_entry.count : i_entry.count + CountW'(1);

        w_proj_upd.seen = 1'b1;
        w_proj_upd.low  = (!i_proj.seen || (i_cdp < i_proj.low))  ? i_cdp : i_proj.low;
        w_proj_upd.high = (!i_proj.seen || (i_cdp > i_proj.high)) ? i_cdp : i_proj.high;

        w_res   = '0;
        w_line  = i_entry;
        w_proj  = i_proj;
        o_wr_en = 1'b0;

        unique case (i_cmd)
            CMD_ADD, CMD_RD_LINE: begin
                if (!i_in_range) begin
                    w_res.status = STS_OUTSIDE;
                end else begin
                    if (i_cmd == CMD_ADD) begin
                        w_line  = w_upd;
                        w_proj  = w_proj_upd;
                        o_wr_en = 1'b1;
                    end
                    w_res.trace_count = w_line.count;
                    if (w_line.count == '0) begin
                        w_res.status = STS_EMPTY;
                    end else begin
                        w_res.status   = STS_OK;
                        w_res.cdp_min  = w_line.low;
                        w_res.cdp_max  = w_line.high;
                        w_res.cdp_span = {1'b0, w_line.high} - {1'b0, w_line.low}
                                         + SpanW'(1);
                    end
                end
            end
            CMD_RD_PROJ, CMD_RSVD: begin
                w_res.status = i_proj.seen ? STS_OK : STS_EMPTY;
            end
        endcase

        if (w_proj.seen) begin
            w_res.proj_cdp_min = w_proj.low;
            w_res.proj_cdp_max = w_proj.high;
        end
    end

    assign o_wr_entry  = w_line;
    assign o_proj_next = w_proj;
    assign o_result    = w_res;

endmodule

`default_nettype wire

### hdl/per_line_cdp_range_table.sv
// Top level: per-line CDP range table with project-wide CDP range.
// The item and its table read are registered on acceptance; write-back then loads the output register.
// The table read-modify-write holds input until write-back, so no new item is taken before then.
// A full output register stalls write-back, and with it the next item.
// Reset: synchronous, active low; clears control, project range and line_base,
// then a clearing pass over all LINES entries zeroes every trace count before input is taken.
`default_nettype none

module per_line_cdp_range_table
    import plcr_pkg::*;
#(
    parameter int LINES = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration: line_base
    input  wire logic              i_cfg_we,
    input  wire logic [LineW-1:0]  i_cfg_wdata,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [LineW-1:0]  i_line_no,
    input  wire logic [CdpW-1:0]   i_cdp_no,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_status,
    output logic [CdpW-1:0]        o_cdp_min,
    output logic [CdpW-1:0]        o_cdp_max,
    output logic [SpanW-1:0]       o_cdp_span,
    output logic [CountW-1:0]      o_trace_count,
    output logic [CdpW-1:0]        o_proj_cdp_min,
    output logic [CdpW-1:0]        o_proj_cdp_max
);

    localparam int AW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [AW-1:0] LastSlot = AW'(LINES - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [LineW-1:0]   r_line_base;

    // item held during the table access
    t_cmd               r_cmd;
    logic               r_in_range;
    logic [AW-1:0]      r_slot;
    logic [CdpW-1:0]    r_cdp;

    t_proj              r_proj;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_accept;
    logic               w_done;
    logic [LineW:0]     w_diff;
    logic               w_in_range;

    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    t_entry             w_ram_wdata;
    t_entry             w_rd_entry;

    logic               w_calc_we;
    t_entry             w_calc_entry;
    t_proj              w_proj_next;
    t_result            w_result;

    // slot = line_no - line_base; a borrow or a slot past the table means outside
    assign w_diff     = {1'b0, i_line_no} - {1'b0, r_line_base};
    assign w_in_range = !w_diff[LineW] && (w_diff < (LineW+1)'(LINES));

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    // write-back happens only when the result can move into the output register
    assign w_done   = (r_state == ST_BUSY) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr_addr == LastSlot) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLR;
        endcase
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_base <= '0;
        end else if (i_cfg_we) begin
            r_line_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= t_cmd'(i_command);
            r_in_range <= w_in_range;
            r_slot     <= w_diff[AW-1:0];
            r_cdp      <= i_cdp_no;
        end
    end

    // Table write port: zero fill during clearing, write-back otherwise.
    // Reads only start in IDLE, after write-back, so no same-entry overlap.
    assign w_ram_we    = (r_state == ST_CLR) || (w_done && w_calc_we);
    assign w_ram_waddr = (r_state == ST_CLR) ? r_clr_addr : r_slot;
    assign w_ram_wdata = (r_state == ST_CLR) ? t_entry'('0) : w_calc_entry;

    plcr_ram #(
        .DEPTH (LINES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_diff[AW-1:0]),
        .o_rdata (w_rd_entry)
    );

    plcr_calc u_calc (
        .i_cmd       (r_cmd),
        .i_in_range  (r_in_range),
        .i_cdp       (r_cdp),
        .i_entry     (w_rd_entry),
        .i_proj      (r_proj),
        .o_wr_en     (w_calc_we),
        .o_wr_entry  (w_calc_entry),
        .o_proj_next (w_proj_next),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj <= '0;
        end else if (w_done) begin
            r_proj <= w_proj_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_cdp_min      = r_out.cdp_min;
    assign o_cdp_max      = r_out.cdp_max;
    assign o_cdp_span     = r_out.cdp_span;
    assign o_trace_count  = r_out.trace_count;
    assign o_proj_cdp_min = r_out.proj_cdp_min;
    assign o_proj_cdp_max = r_out.proj_cdp_max;

`ifndef NO_ASSERTIONS
    // a table read never coincides with a table write
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_accept))
        else $error("table read and write in the same cycle");

    a_proj_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_proj.seen |-> (r_proj.low <= r_proj.high))
        else $error("project range inverted");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STS_OUTSIDE)) |->
        ((r_out.trace_count == '0) && (r_out.cdp_span == '0)))
        else $error("outside-table result carries line fields");

    a_ok_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STS_OK) && (r_out.trace_count != '0)) |->
        (r_out.cdp_min <= r_out.cdp_max))
        else $error("line range inverted");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_BUSY))
        else $error("accepted item not in table access");
`endif

endmodule

`default_nettype wire

### dv/plcr_checker.sv
// Checker for the per-line CDP range table: predicts every answer and compares the result channel.
`timescale 1ns / 100ps

module plcr_checker
    import plcr_pkg::*;
#(
    parameter int LINES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LineW-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_command,
    input  logic [LineW-1:0]  i_line_no,
    input  logic [CdpW-1:0]   i_cdp_no,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_status,
    input  logic [CdpW-1:0]   i_cdp_min,
    input  logic [CdpW-1:0]   i_cdp_max,
    input  logic [SpanW-1:0]  i_cdp_span,
    input  logic [CountW-1:0] i_trace_count,
    input  logic [CdpW-1:0]   i_proj_cdp_min,
    input  logic [CdpW-1:0]   i_proj_cdp_max,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    // Shadow of the line table, project range and line base
    logic [CdpW-1:0]   low_tab   [LINES];
    logic [CdpW-1:0]   high_tab  [LINES];
    logic [CountW-1:0] count_tab [LINES];
    t_proj             proj;
    logic [LineW-1:0]  base;
    t_result           answers_due[$];

    // Applies one command to the shadow table and returns the answer it must produce.
    function automatic t_result table_answer(input logic [1:0] cmd,
                                             input logic [LineW-1:0] line,
                                             input logic [CdpW-1:0] cdp);
        t_result ans;
        int      slot;
        logic    in_table;
        ans      = '0;
        slot     = int'(line) - int'(base);
        in_table = (slot >= 0) && (slot < LINES);
        if (cmd == CMD_ADD || cmd == CMD_RD_LINE) begin
            if (!in_table) begin
                ans.status = STS_OUTSIDE;
            end else begin
                if (cmd == CMD_ADD) begin
                    if (count_tab[slot] == '0) begin
                        low_tab[slot]  = cdp;
                        high_tab[slot] = cdp;
                    end else begin
                        if (cdp < low_tab[slot])  low_tab[slot]  = cdp;
                        if (cdp > high_tab[slot]) high_tab[slot] = cdp;
                    end
                    if (count_tab[slot] != '1) count_tab[slot] = count_tab[slot] + 1'b1;
                    if (!proj.seen) begin
                        proj.seen = 1'b1;
                        proj.low  = cdp;
                        proj.high = cdp;
                    end else begin
                        if (cdp < proj.low)  proj.low  = cdp;
                        if (cdp > proj.high) proj.high = cdp;
                    end
                end
                ans.trace_count = count_tab[slot];
                if (count_tab[slot] == '0) begin
                    ans.status = STS_EMPTY;
                end else begin
                    ans.status   = STS_OK;
                    ans.cdp_min  = low_tab[slot];
                    ans.cdp_max  = high_tab[slot];
                    ans.cdp_span = {1'b0, high_tab[slot]} - {1'b0, low_tab[slot]} + 1'b1;
                end
            end
        end else begin
            // project read; the spare command code reads the project too
            ans.status = proj.seen ? STS_OK : STS_EMPTY;
        end
        if (proj.seen) begin
            ans.proj_cdp_min = proj.low;
            ans.proj_cdp_max = proj.high;
        end
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < LINES; k++) count_tab[k] = '0;
            proj = '0;
            base = '0;
            answers_due.delete();
            o_errors  = 0;
            o_pending = 0;
            o_checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result arrived with no command waiting for it");
                    o_errors++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("status",       want.status,       i_status);
                    check_field("cdp_min",      want.cdp_min,      i_cdp_min);
                    check_field("cdp_max",      want.cdp_max,      i_cdp_max);
                    check_field("cdp_span",     want.cdp_span,     i_cdp_span);
                    check_field("trace_count",  want.trace_count,  i_trace_count);
                    check_field("proj_cdp_min", want.proj_cdp_min, i_proj_cdp_min);
                    check_field("proj_cdp_max", want.proj_cdp_max, i_proj_cdp_max);
                    o_checked++;
                end
            end
            if (i_cfg_we) base = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                answers_due.push_back(table_answer(i_command, i_line_no, i_cdp_no));
            o_pending = answers_due.size();
        end
    end

endmodule

### dv/tb_per_line_cdp_range_table.sv
// Testbench top for the per-line CDP range table: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_per_line_cdp_range_table;
    import plcr_pkg::*;

    localparam int LINES       = 1024;
    localparam int PHASE_ITEMS = 106;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [LineW-1:0]  i_cfg_wdata = '0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [1:0]        i_command   = '0;
    logic [LineW-1:0]  i_line_no   = '0;
    logic [CdpW-1:0]   i_cdp_no    = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [1:0]        o_status;
    logic [CdpW-1:0]   o_cdp_min;
    logic [CdpW-1:0]   o_cdp_max;
    logic [SpanW-1:0]  o_cdp_span;
    logic [CountW-1:0] o_trace_count;
    logic [CdpW-1:0]   o_proj_cdp_min;
    logic [CdpW-1:0]   o_proj_cdp_max;

    int   errors;
    int   pending;
    int   checked;
    int   cmd_seen [4];
    int   bases_used;
    // no random idling on either side while set
    logic steady = 1'b0;

    per_line_cdp_range_table #(.LINES(LINES)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_line_no      (i_line_no),
        .i_cdp_no       (i_cdp_no),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_cdp_min      (o_cdp_min),
        .o_cdp_max      (o_cdp_max),
        .o_cdp_span     (o_cdp_span),
        .o_trace_count  (o_trace_count),
        .o_proj_cdp_min (o_proj_cdp_min),
        .o_proj_cdp_max (o_proj_cdp_max)
    );

    plcr_checker #(.LINES(LINES)) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_command      (i_command),
        .i_line_no      (i_line_no),
        .i_cdp_no       (i_cdp_no),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_status       (o_status),
        .i_cdp_min      (o_cdp_min),
        .i_cdp_max      (o_cdp_max),
        .i_cdp_span     (o_cdp_span),
        .i_trace_count  (o_trace_count),
        .i_proj_cdp_min (o_proj_cdp_min),
        .i_proj_cdp_max (o_proj_cdp_max),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: drops ready at random, about 7 percent of the time, never while steady
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= 7);
    end

    // Hands one item to the block; entered and left at a falling edge.
    // May first drop valid and idle at random. Valid stays high until accepted.
    task automatic send_item(input t_cmd cmd, input logic [LineW-1:0] line,
                             input logic [CdpW-1:0] cdp);
        if (!steady && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_line_no <= line;
        i_cdp_no  <= cdp;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        cmd_seen[cmd]++;
    endtask

    // Holds off the sender until every outstanding answer has come back.
    // Always reaches a falling edge first, so valid is never re-raised in the same step.
    task automatic drain;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // line_base only changes while the block is idle: drained, then latency slack
    task automatic set_line_base(input logic [LineW-1:0] value);
        drain;
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        bases_used++;
    endtask

    // Random traffic around one line_base. Most lines land in the table, clustered
    // on a few entries so min/max/count keep changing; the rest are stray line
    // numbers and off-by-one neighbors of the table's edges.
    task automatic run_phase(input int base, input int items, input int pause_at);
        int   top_slot;
        int   pick;
        int   line_i;
        logic [CdpW-1:0] cdp;
        t_cmd cmd;
        top_slot = (65535 - base < LINES - 1) ? 65535 - base : LINES - 1;
        for (int k = 0; k < items; k++) begin
            if (k == pause_at) drain;
            steady <= (k >= 30 && k < 60);

            pick = $urandom_range(0, 99);
            if (pick < 55)      cmd = CMD_ADD;
            else if (pick < 80) cmd = CMD_RD_LINE;
            else if (pick < 93) cmd = CMD_RD_PROJ;
            else                cmd = CMD_RSVD;

            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                line_i = $urandom_range(0, 65535);
            end else if (pick == 2) begin
                // just outside either edge of the table
                if (base > 0 && ($urandom_range(0, 1) == 1 || base + LINES > 65535))
                    line_i = base - 1;
                else if (base + LINES <= 65535)
                    line_i = base + LINES;
                else
                    line_i = $urandom_range(0, 65535);
            end else if (pick == 3) begin
                line_i = base + ($urandom_range(0, 1) ? top_slot : 0);
            end else if (pick < 6) begin
                line_i = base + $urandom_range(0, top_slot);
            end else begin
                line_i = base + $urandom_range(0, (top_slot < 7) ? top_slot : 7);
            end

            pick = $urandom_range(0, 9);
            if (pick == 0)      cdp = '0;
            else if (pick == 1) cdp = '1;
            else                cdp = CdpW'($urandom_range(0, 65535));

            send_item(cmd, line_i[LineW-1:0], cdp);
        end
        steady <= 1'b0;
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty project and empty line, reserved code as a project read
        send_item(CMD_RD_PROJ, 16'd0, 16'd0);
        send_item(CMD_RSVD,    16'd0, 16'd0);
        send_item(CMD_RD_LINE, 16'd0, 16'd0);
        // first record sets the project range; widest possible span next
        send_item(CMD_ADD,     16'd0, 16'd0);
        send_item(CMD_ADD,     16'd0, 16'hFFFF);
        send_item(CMD_RD_LINE, 16'd0, 16'd0);
        // top entry, back-to-back updates of the same line
        send_item(CMD_ADD,     16'd1023, 16'd100);
        send_item(CMD_ADD,     16'd1023, 16'd50);
        send_item(CMD_ADD,     16'd1023, 16'd200);
        // one past the table and the largest line number: outside, add ignored
        send_item(CMD_ADD,     16'd1024, 16'd5);
        send_item(CMD_RD_LINE, 16'd1024, 16'd0);
        send_item(CMD_RD_LINE, 16'hFFFF, 16'hFFFF);
        send_item(CMD_RD_PROJ, 16'd0, 16'd0);
        send_item(CMD_RSVD,    16'hFFFF, 16'hFFFF);

        // Largest base: only line 65535 fits, and it maps onto entry zero
        set_line_base(16'hFFFF);
        send_item(CMD_RD_LINE, 16'hFFFF, 16'd0);
        send_item(CMD_ADD,     16'hFFFF, 16'd7);
        send_item(CMD_ADD,     16'hFFFE, 16'd9);
        send_item(CMD_RD_LINE, 16'd0, 16'd0);

        // Base where the table's last entry is line 65535
        set_line_base(16'd64512);
        send_item(CMD_RD_LINE, 16'hFFFF, 16'd0);
        send_item(CMD_ADD,     16'd64511, 16'd3);
        send_item(CMD_ADD,     16'hFFFF, 16'hFFFF);
        send_item(CMD_RD_PROJ, 16'd0, 16'd0);

        // Random phases at fixed bases, extremes included, then at a random base
        set_line_base(16'd0);
        run_phase(0, PHASE_ITEMS, -1);
        set_line_base(16'd300);
        run_phase(300, PHASE_ITEMS, 50);
        set_line_base(16'd64512);
        run_phase(64512, PHASE_ITEMS, -1);
        set_line_base(16'hFFFF);
        run_phase(65535, PHASE_ITEMS, -1);
        begin
            int rand_base;
            rand_base = $urandom_range(0, 65535);
            set_line_base(rand_base[LineW-1:0]);
            run_phase(rand_base, PHASE_ITEMS, -1);
        end

        drain;
        repeat (8) @(negedge i_clk);

        $display("Sent %0d adds, %0d line reads, %0d project reads, %0d spare-code reads",
                 cmd_seen[CMD_ADD], cmd_seen[CMD_RD_LINE], cmd_seen[CMD_RD_PROJ],
                 cmd_seen[CMD_RSVD]);
        $display("Checked %0d results across %0d line_base settings", checked, bases_used);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, clearing pass included
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### per_line_cdp_range_table.f
hdl/plcr_pkg.sv
hdl/plcr_ram.sv
hdl/plcr_calc.sv
hdl/per_line_cdp_range_table.sv
dv/plcr_checker.sv
dv/tb_per_line_cdp_range_table.sv
